### sv/canids_pkg.sv
// Package for the CAN identifier frame statistics core.
// Holds the beat payload types, result status codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package canids_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned IDENT_W     = 29;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned COUNT_W     = 20;
  localparam int unsigned SUM_W       = 23;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned DISTINCT_W  = 7;

  localparam logic [COUNT_W-1:0] FRAME_LIMIT_RST = 20'd1024;
  localparam logic [LEN_W-1:0]   MAX_LEN         = 4'd8;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [IDENT_W-1:0] frame_ident;
    logic [LEN_W-1:0]   length_code;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [INDEX_W-1:0]    entry_index;
    logic [COUNT_W-1:0]    entry_count;
    logic [SUM_W-1:0]      entry_length_sum;
    logic [DISTINCT_W-1:0] distinct_count;
    logic [COUNT_W-1:0]    frames_accepted;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit_ignore;
    logic commit_hit;
    logic commit_new;
  } ctl_cmd_t;

  typedef struct packed {
    logic over_limit;
    logic match;
    logic exhausted;
  } ctl_sts_t;

endpackage

`default_nettype wire

### sv/canids_ctrl.sv
// Controller state machine of the CAN identifier frame statistics core.
// Sequences accept, table scan, commit and result beat; depends on canids_pkg.
`default_nettype none

module canids_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      out_strobe,
  output canids_pkg::ctl_cmd_t      cmd,
  input  wire canids_pkg::ctl_sts_t sts
);
  import canids_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.over_limit) begin
            cmd.commit_ignore = 1'b1;
            state_nxt         = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.match) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.exhausted) begin
          cmd.commit_new = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

endmodule

`default_nettype wire

### sv/canids_dpath.sv
// Datapath of the CAN identifier frame statistics core: entry memory, scan pipeline,
// counters, frame limit register and result register; depends on canids_pkg.
`default_nettype none

module canids_dpath #(
  parameter int unsigned ENTRIES = canids_pkg::ENTRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire canids_pkg::in_t           in_data,
  input  wire logic                      cfg_we,
  input  wire logic [canids_pkg::COUNT_W-1:0] cfg_wdata,
  input  wire canids_pkg::ctl_cmd_t      cmd,
  output canids_pkg::ctl_sts_t           sts,
  output canids_pkg::out_t               out_data
);
  import canids_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } ent_t;

  ent_t mem [ENTRIES];
  ent_t rd_data_r;
  ent_t wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  logic [IDENT_W-1:0] ident_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_sat;
  logic [CNT_W-1:0]   scan_addr_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_valid_r;
  logic               issue;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [COUNT_W-1:0] accepted_r, accepted_nxt;
  logic [COUNT_W-1:0] limit_r;
  logic               new_ok;
  logic [COUNT_W-1:0] count_new;
  logic [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]   len_ext;
  logic [IDX_W+5:0]   cmp_idx_ext;
  logic [IDX_W+5:0]   used_idx_ext;
  logic [CNT_W+6:0]   dist_ext;
  out_t               out_r, out_nxt;

  assign len_sat = (in_data.length_code > MAX_LEN) ? MAX_LEN : in_data.length_code;
  assign len_ext = {{(SUM_W-LEN_W){1'b0}}, len_r};

  assign issue = cmd.scan && (scan_addr_r < used_r);

  assign sts.over_limit = (accepted_r >= limit_r);
  assign sts.match      = cmp_valid_r && (rd_data_r.ident == ident_r);
  assign sts.exhausted  = !cmp_valid_r && (scan_addr_r >= used_r);

  assign new_ok    = (used_r < ENTRIES_C);
  assign count_new = rd_data_r.count + COUNT_W'(1);
  assign sum_new   = rd_data_r.sum + len_ext;

  assign cmp_idx_ext  = {6'b0, cmp_idx_r};
  assign used_idx_ext = {6'b0, used_r[IDX_W-1:0]};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx_r;
    wr_data = '{ident: ident_r, count: count_new, sum: sum_new};
    if (cmd.commit_hit) begin
      wr_en = 1'b1;
    end else if (cmd.commit_new && new_ok) begin
      wr_en   = 1'b1;
      wr_addr = used_r[IDX_W-1:0];
      wr_data = '{ident: ident_r, count: COUNT_W'(1), sum: len_ext};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[scan_addr_r[IDX_W-1:0]];
  end

  always_comb begin
    used_nxt     = used_r;
    accepted_nxt = accepted_r;
    if (cmd.commit_hit || cmd.commit_new) begin
      accepted_nxt = accepted_r + COUNT_W'(1);
    end
    if (cmd.commit_new && new_ok) begin
      used_nxt = used_r + CNT_W'(1);
    end
  end

  assign dist_ext = {7'b0, used_nxt};

  always_comb begin
    out_nxt                 = out_r;
    out_nxt.distinct_count  = dist_ext[DISTINCT_W-1:0];
    out_nxt.frames_accepted = accepted_nxt;
    out_nxt.status           = ST_IGNORED;
    out_nxt.entry_index      = '0;
    out_nxt.entry_count      = '0;
    out_nxt.entry_length_sum = '0;
    if (cmd.commit_hit) begin
      out_nxt.status           = ST_UPDATED;
      out_nxt.entry_index      = cmp_idx_ext[INDEX_W-1:0];
      out_nxt.entry_count      = count_new;
      out_nxt.entry_length_sum = sum_new;
    end else if (cmd.commit_new && new_ok) begin
      out_nxt.status           = ST_CREATED;
      out_nxt.entry_index      = used_idx_ext[INDEX_W-1:0];
      out_nxt.entry_count      = COUNT_W'(1);
      out_nxt.entry_length_sum = len_ext;
    end else if (cmd.commit_new) begin
      out_nxt.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ident_r <= in_data.frame_ident;
      len_r   <= len_sat;
    end
    if (cmd.commit_ignore || cmd.commit_hit || cmd.commit_new) begin
      out_r <= out_nxt;
    end
    cmp_idx_r <= scan_addr_r[IDX_W-1:0];
    if (cmd.load) begin
      scan_addr_r <= '0;
    end else if (issue) begin
      scan_addr_r <= scan_addr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      accepted_r  <= '0;
      limit_r     <= FRAME_LIMIT_RST;
      cmp_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      accepted_r  <= accepted_nxt;
      cmp_valid_r <= issue && !cmd.load;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### sv/can_id_frame_statistics_core.sv
// Top level of the CAN identifier frame statistics core.
// Joins the controller and the datapath; depends on canids_pkg, canids_ctrl, canids_dpath.
//
// Usage: an input beat (frame identifier and length code) is taken at a rising edge
// with start high and busy low. Busy stays high until the result beat has been shown.
// Each result is marked valid on out_data by out_strobe, high for exactly one cycle; the
// receiver cannot stall, so it must take every beat in that cycle.
// The table is searched one entry per cycle from a registered memory read port.
// The accepted frame's identifier is compared with each entry read in turn; a match
// updates that entry, and a new identifier, once the held identifiers are exhausted,
// creates an entry or, when the table is full, gives a full status.
// A frame over the limit goes straight to the result beat with the ignored status.
// The core passes through its idle state between items.
// The frame limit is written through cfg_we and cfg_wdata while the core is idle.
// Synchronous reset empties the table, clears the frame total and sets the limit
// to 1024; table contents themselves are not cleared.
`default_nettype none

module can_id_frame_statistics_core #(
  parameter int unsigned ENTRIES = canids_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire canids_pkg::in_t                in_data,
  output logic                                out_strobe,
  output canids_pkg::out_t                    out_data,
  input  wire logic                           cfg_we,
  input  wire logic [canids_pkg::COUNT_W-1:0] cfg_wdata
);
  import canids_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  canids_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  canids_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
